// ===== sv/hsbp_pkg.sv =====
// Shared types and constants for the Huffman symbol bit packer.
package hsbp_pkg;

	localparam int unsigned CODE_W  = 16;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned HELD_W  = 3;
	localparam int unsigned ACC_W   = 7;
	localparam int unsigned MERGE_W = ACC_W + CODE_W;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_FLUSH  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef struct packed {
		logic [1:0]        count;
		logic [BYTE_W-1:0] byte0;
		logic [BYTE_W-1:0] byte1;
		logic              last;
	} pack_out_t;

endpackage

// ===== sv/hsbp_code_table.sv =====
// Code table memory: one code and length per symbol, registered read.
module hsbp_code_table #(
	parameter int unsigned SYMBOL_COUNT = 256,
	parameter int unsigned IDX_W        = 8
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           addr,
	input  logic [hsbp_pkg::LEN_W-1:0]  wr_len,
	input  logic [hsbp_pkg::CODE_W-1:0] wr_code,
	output logic [hsbp_pkg::LEN_W-1:0]  rd_len,
	output logic [hsbp_pkg::CODE_W-1:0] rd_code
);
	import hsbp_pkg::*;

	logic [LEN_W+CODE_W-1:0] mem [SYMBOL_COUNT];
	logic [LEN_W+CODE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= {wr_len, wr_code};
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_len  = rd_q[LEN_W+CODE_W-1:CODE_W];
	assign rd_code = rd_q[CODE_W-1:0];

endmodule

// ===== sv/hsbp_packer.sv =====
// Bit accumulator with shift-merge: appends one code and emits up to two bytes, or flushes the partial byte.
module hsbp_packer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  hsbp_pkg::req_t              req,
	input  logic                        hit,
	input  logic [hsbp_pkg::LEN_W-1:0]  len,
	input  logic [hsbp_pkg::CODE_W-1:0] code,
	output hsbp_pkg::pack_out_t         res
);
	import hsbp_pkg::*;

	logic [ACC_W-1:0]   acc_q;
	logic [HELD_W-1:0]  held_q;
	logic [MERGE_W-1:0] merged;
	logic [LEN_W-1:0]   total;
	logic [MERGE_W:0]   aligned;
	logic [ACC_W:0]     keep_mask;
	logic [BYTE_W-1:0]  flush_byte;
	logic [ACC_W-1:0]   acc_d;
	logic [HELD_W-1:0]  held_d;

	assign merged     = (MERGE_W'(acc_q) << len) | MERGE_W'(code);
	assign total      = LEN_W'(held_q) + len;
	assign aligned    = {1'b0, merged} << (LEN_W'(MERGE_W + 1) - total);
	assign keep_mask  = ((ACC_W+1)'(1) << total[HELD_W-1:0]) - (ACC_W+1)'(1);
	assign flush_byte = {1'b0, acc_q} << (4'd8 - {1'b0, held_q});

	always_comb begin
		res    = '0;
		acc_d  = acc_q;
		held_d = held_q;
		unique case (req)
			REQ_ENCODE: begin
				if (hit) begin
					res.count = total[LEN_W-1:HELD_W];
					res.byte0 = aligned[MERGE_W:MERGE_W-BYTE_W+1];
					res.byte1 = aligned[MERGE_W-BYTE_W:MERGE_W-2*BYTE_W+1];
					acc_d     = merged[ACC_W-1:0] & keep_mask[ACC_W-1:0];
					held_d    = total[HELD_W-1:0];
				end
			end
			REQ_FLUSH: begin
				res.count = 2'd1;
				res.byte0 = flush_byte;
				res.last  = 1'b1;
				acc_d     = '0;
				held_d    = '0;
			end
			default: begin
			end
		endcase
		if (!en) begin
			res.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
		end else if (en) begin
			acc_q  <= acc_d;
			held_q <= held_d;
		end
	end

endmodule

// ===== sv/hsbp_out_fifo.sv =====
// Four-entry output queue: takes up to two words a cycle, gives one while m_tready is high.
module hsbp_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hsbp_pkg::pack_out_t         push,
	output logic                        room,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [hsbp_pkg::BYTE_W-1:0] m_tdata,
	output logic                        m_tlast
);
	import hsbp_pkg::*;

	logic [BYTE_W:0] mem [4];
	logic [1:0]      wr_q;
	logic [1:0]      rd_q;
	logic [2:0]      cnt_q;
	logic            pop;

	assign room     = (cnt_q <= 3'd2);
	assign m_tvalid = (cnt_q != 3'd0);
	assign pop      = m_tvalid & m_tready;
	assign m_tdata  = mem[rd_q][BYTE_W-1:0];
	assign m_tlast  = mem[rd_q][BYTE_W];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= {push.last, push.byte0};
		end
		if (push.count == 2'd2) begin
			mem[wr_q + 2'd1] <= {1'b0, push.byte1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push.count) - 3'(pop);
		end
	end

endmodule

// ===== sv/huffman_symbol_bit_packer_unit.sv =====
// Huffman symbol bit packer top level. A word on the slave side is a load
// (write one code-table entry), an encode (append the symbol's code MSB
// first to the bit accumulator) or a flush (pad the partial byte with zeros
// and emit it with tlast high; a flush always emits a byte). One word is
// accepted per cycle unless a word waits in stage 1 while the output queue
// lacks room. The code table is read into its output register on acceptance,
// and the merge result is queued when the stage-1 word advances. The output
// port carries one byte per cycle while m_tready is high, so an encode that
// completes two bytes holds it longer; the item rate is limited by the
// one-byte output port behind a four-entry queue. Table entries must be
// loaded before they are encoded.
module huffman_symbol_bit_packer_unit #(
	parameter int unsigned MAX_CODE_LEN = 16,
	parameter int unsigned SYMBOL_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // symbol[7:0], code_bits[23:8], code_length[28:24], zeros
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte[7:0]
	output logic        m_tlast
);
	import hsbp_pkg::*;

	localparam int unsigned IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int unsigned LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

	logic [BYTE_W-1:0] symbol;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_length;
	req_t              req_type;
	logic              sym_ok;
	logic              accept;
	logic [LEN_W-1:0]  load_len;
	logic [CODE_W:0]   load_mask;
	logic [LEN_W-1:0]  rd_len;
	logic [CODE_W-1:0] rd_code;
	logic              room;
	logic              advance;
	pack_out_t         pack_res;

	logic              valid_s1;
	req_t              req_s1;
	logic              hit_s1;

	assign symbol      = s_tdata[7:0];
	assign code_bits   = s_tdata[23:8];
	assign code_length = s_tdata[28:24];
	assign req_type    = req_t'(s_tuser);

	assign sym_ok    = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
	assign load_len  = (code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length;
	assign load_mask = ((CODE_W+1)'(1) << load_len) - (CODE_W+1)'(1);

	assign advance  = valid_s1 & room;
	assign s_tready = !valid_s1 | room;
	assign accept   = s_tvalid & s_tready;

	hsbp_code_table #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.IDX_W       (IDX_W)
	) u_table (
		.clk    (clk),
		.wr_en  (accept && req_type == REQ_LOAD && sym_ok),
		.rd_en  (accept && req_type == REQ_ENCODE),
		.addr   (symbol[IDX_W-1:0]),
		.wr_len (load_len),
		.wr_code(code_bits & load_mask[CODE_W-1:0]),
		.rd_len (rd_len),
		.rd_code(rd_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			hit_s1 <= sym_ok;
		end
	end

	hsbp_packer u_packer (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.req   (req_s1),
		.hit   (hit_s1),
		.len   (rd_len),
		.code  (rd_code),
		.res   (pack_res)
	);

	hsbp_out_fifo u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (pack_res),
		.room    (room),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
